/* sv/assert_macros.svh */
// Assertion macros used by the RTL of the interval tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every rising clk edge outside reset.
`define DIT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never be true on a rising clk edge outside reset.
`define DIT_ASSERT_NEVER(label, cond, msg) \
	`DIT_ASSERT(label, !(cond), msg)

`endif

/* sv/dit_pkg.sv */
// Shared types and constants of the disjoint interval tracker.
`timescale 1ns / 1ps

package dit_pkg;

	// Default size of the tracked universe and fixed field widths.
	localparam int UNIVERSE_DEF = 1024;
	localparam int VALUE_W = 10;

	// The presence map is kept as words of this many bits.
	localparam int WORD_W = 64;
	localparam int OFF_W = 6;

	typedef enum logic {
		CMD_ADD   = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef struct packed {
		cmd_t                command;
		logic [VALUE_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic                found;
		logic                already_present;
		logic [VALUE_W-1:0]  run_low;
		logic [VALUE_W-1:0]  run_high;
	} rsp_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_A_RD,
		S_A_CHK,
		S_A_PREV,
		S_A_NEXT,
		S_A_LCHK,
		S_A_HCHK,
		S_A_W1,
		S_A_W2,
		S_D_SCAN,
		S_Q_START,
		S_Q_CARRY,
		S_Q_SCAN,
		S_H_RD,
		S_H_GET,
		S_DONE
	} state_t;

endpackage

/* sv/dit_ram.sv */
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps

module dit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write on request; the read returns the old contents in the next cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* sv/disjoint_interval_tracker.sv */
// Top level of the disjoint interval tracker: sequencer, presence map and run-end store.
// The tracker keeps the values seen so far as maximal runs of consecutive values. An add
// request marks a value present, merges it with its neighbors and returns the run that holds
// it; a query request returns the first run whose low end is at or above the given value, so
// software walks all runs by querying again from the last run_high plus two. One request is
// handled at a time and the response sits in an output register, so the next request is taken
// while a response still waits. The presence map is a RAM of 64-bit words and the run ends
// live in a second RAM; every step is one access to either memory. An add of a value already
// present scans downward one 64-bit word at a time to the run's low end. A query that finds a
// run scans upward one 64-bit word at a time from the start value's word, at most UNIVERSE/64
// words; a query that finds none scans the same way to the last word. The next request can be
// accepted in the same cycle as the response appears at the earliest. After reset the presence
// map is cleared one word per cycle before the first request is accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module disjoint_interval_tracker #(
	parameter int UNIVERSE = dit_pkg::UNIVERSE_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dit_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dit_pkg::rsp_t rsp_data
);

	import dit_pkg::*;

	localparam int NWORDS = (UNIVERSE + WORD_W - 1) / WORD_W;
	localparam int WAW = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int PW = WAW + OFF_W;
	localparam int AW = $clog2(UNIVERSE);
	localparam int EP_DEPTH = 2 * UNIVERSE;
	localparam int EAW = $clog2(EP_DEPTH);
	localparam logic [WAW-1:0] LAST_WORD = WAW'(NWORDS - 1);
	localparam logic [EAW-1:0] LOW_BASE = EAW'(UNIVERSE);

	// Index of the lowest set bit of a word.
	function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_W-1:0] vec);
		logic [OFF_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (vec[i]) begin
				idx = OFF_W'(i);
			end
		end
		return idx;
	endfunction

	// Index of the highest set bit of a word.
	function automatic logic [OFF_W-1:0] highest_set(input logic [WORD_W-1:0] vec);
		logic [OFF_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_W; i++) begin
			if (vec[i]) begin
				idx = OFF_W'(i);
			end
		end
		return idx;
	endfunction

	// Control state.
	state_t         state_q;
	state_t         state_d;
	logic [WAW-1:0] clr_q;
	logic           rsp_valid_q;
	rsp_t           rsp_q;
	logic           rsp_load;
	logic           req_fire;
	logic           req_in_range;

	// Working registers of the current request.
	cmd_t              cmd_q;
	logic [PW-1:0]     pos_q;
	logic [WORD_W-1:0] word_q;
	logic              left_q;
	logic              right_q;
	logic              carry_q;
	logic              first_q;
	logic [WAW-1:0]    chk_q;
	logic [AW-1:0]     lo_q;
	logic [AW-1:0]     hi_q;
	rsp_t              res_q;

	// Memory ports.
	logic              pres_we;
	logic [WAW-1:0]    pres_addr;
	logic [WORD_W-1:0] pres_wdata;
	logic [WORD_W-1:0] pres_rdata;
	logic              ep_we;
	logic [EAW-1:0]    ep_addr;
	logic [AW-1:0]     ep_wdata;
	logic [AW-1:0]     ep_rdata;

	// Derived values.
	logic [WAW-1:0]    word_idx;
	logic [OFF_W-1:0]  off;
	logic [WAW-1:0]    prev_word;
	logic [WAW-1:0]    next_word;
	logic              next_ok;
	logic [WAW-1:0]    chk_prev;
	logic [WAW-1:0]    chk_next;
	logic              chk_next_ok;
	logic              bit_here;
	logic [WORD_W-1:0] dn_vec;
	logic              dn_any;
	logic [WAW-1:0]    dn_word;
	logic [AW-1:0]     dn_low;
	logic [WORD_W-1:0] q_mask;
	logic [WORD_W-1:0] starts;
	logic              st_any;
	logic [OFF_W-1:0]  st_lsb;

	// Presence map, one bit per value, packed into words.
	dit_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NWORDS)
	) u_pres_ram (
		.clk  (clk),
		.we   (pres_we),
		.addr (pres_addr),
		.wdata(pres_wdata),
		.rdata(pres_rdata)
	);

	// Run ends: the high end of a run at its start, then the low end at its end.
	dit_ram #(
		.WIDTH(AW),
		.DEPTH(EP_DEPTH)
	) u_ep_ram (
		.clk  (clk),
		.we   (ep_we),
		.addr (ep_addr),
		.wdata(ep_wdata),
		.rdata(ep_rdata)
	);

	// Word and bit position of the request value and of the scan pointer.
	assign word_idx    = pos_q[PW-1:OFF_W];
	assign off         = pos_q[OFF_W-1:0];
	assign prev_word   = (word_idx == '0) ? '0 : word_idx - 1'b1;
	assign next_ok     = 32'(word_idx) < NWORDS - 1;
	assign next_word   = next_ok ? word_idx + 1'b1 : word_idx;
	assign chk_prev    = (chk_q == '0) ? '0 : chk_q - 1'b1;
	assign chk_next_ok = 32'(chk_q) < NWORDS - 1;
	assign chk_next    = chk_next_ok ? chk_q + 1'b1 : chk_q;
	assign bit_here    = pres_rdata[off];

	// Downward search for the gap below a present value.
	assign dn_vec  = (state_q == S_A_CHK) ? (~pres_rdata & ((WORD_W'(1) << off) - WORD_W'(1)))
	                                      : ~pres_rdata;
	assign dn_any  = |dn_vec;
	assign dn_word = (state_q == S_A_CHK) ? word_idx : chk_q;
	assign dn_low  = AW'({dn_word, highest_set(dn_vec)} + PW'(1));

	// Upward search for a run start: a set bit whose lower neighbor is clear.
	assign q_mask = first_q ? ({WORD_W{1'b1}} << off) : {WORD_W{1'b1}};
	assign starts = pres_rdata & ~{pres_rdata[WORD_W-2:0], carry_q} & q_mask;
	assign st_any = |starts;
	assign st_lsb = lowest_set(starts);

	assign req_fire     = req_valid && req_ready;
	assign req_in_range = 32'(req_data.value) < UNIVERSE;

	// State register and the registers that reset must clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Next state and memory control.
	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		rsp_load   = 1'b0;
		pres_we    = 1'b0;
		pres_addr  = word_idx;
		pres_wdata = word_q | (WORD_W'(1) << off);
		ep_we      = 1'b0;
		ep_addr    = EAW'(lo_q);
		ep_wdata   = hi_q;
		unique case (state_q)
			S_CLEAR: begin
				pres_we    = 1'b1;
				pres_addr  = clr_q;
				pres_wdata = '0;
				if (clr_q == LAST_WORD) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					if (!req_in_range) begin
						state_d = S_DONE;
					end else if (req_data.command == CMD_ADD) begin
						state_d = S_A_RD;
					end else begin
						state_d = S_Q_START;
					end
				end
			end
			S_A_RD: begin
				state_d = S_A_CHK;
			end
			S_A_CHK: begin
				pres_addr = prev_word;
				if (!bit_here) begin
					state_d = S_A_PREV;
				end else if (dn_any || word_idx == '0) begin
					state_d = S_H_RD;
				end else begin
					state_d = S_D_SCAN;
				end
			end
			S_A_PREV: begin
				pres_addr = next_word;
				state_d   = S_A_NEXT;
			end
			S_A_NEXT: begin
				ep_addr = LOW_BASE + EAW'(pos_q) - EAW'(1);
				state_d = S_A_LCHK;
			end
			S_A_LCHK: begin
				ep_addr = EAW'(pos_q) + EAW'(1);
				state_d = S_A_HCHK;
			end
			S_A_HCHK: begin
				pres_we = 1'b1;
				state_d = S_A_W1;
			end
			S_A_W1: begin
				ep_we   = 1'b1;
				state_d = S_A_W2;
			end
			S_A_W2: begin
				ep_we    = 1'b1;
				ep_addr  = LOW_BASE + EAW'(hi_q);
				ep_wdata = lo_q;
				state_d  = S_DONE;
			end
			S_D_SCAN: begin
				pres_addr = chk_prev;
				if (dn_any || chk_q == '0) begin
					state_d = S_H_RD;
				end
			end
			S_Q_START: begin
				pres_addr = prev_word;
				state_d   = S_Q_CARRY;
			end
			S_Q_CARRY: begin
				state_d = S_Q_SCAN;
			end
			S_Q_SCAN: begin
				pres_addr = chk_next;
				if (st_any) begin
					state_d = S_H_RD;
				end else if (!chk_next_ok) begin
					state_d = S_DONE;
				end
			end
			S_H_RD: begin
				state_d = S_H_GET;
			end
			S_H_GET: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	// Working registers follow the sequencer.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					cmd_q <= req_data.command;
					pos_q <= PW'(req_data.value);
					res_q <= '0;
				end
			end
			S_A_CHK: begin
				word_q  <= pres_rdata;
				left_q  <= (off != '0) ? pres_rdata[off - 1'b1] : 1'b0;
				right_q <= (off != '1) ? pres_rdata[off + 1'b1] : 1'b0;
				chk_q   <= prev_word;
				lo_q    <= dn_any ? dn_low : '0;
			end
			S_A_PREV: begin
				if (off == '0 && word_idx != '0) begin
					left_q <= pres_rdata[WORD_W-1];
				end
			end
			S_A_NEXT: begin
				if (off == '1 && next_ok) begin
					right_q <= pres_rdata[0];
				end
			end
			S_A_LCHK: begin
				lo_q <= left_q ? ep_rdata : AW'(pos_q);
			end
			S_A_HCHK: begin
				hi_q <= right_q ? ep_rdata : AW'(pos_q);
			end
			S_A_W2: begin
				res_q.found           <= 1'b1;
				res_q.already_present <= 1'b0;
				res_q.run_low         <= VALUE_W'(lo_q);
				res_q.run_high        <= VALUE_W'(hi_q);
			end
			S_D_SCAN: begin
				chk_q <= chk_prev;
				lo_q  <= dn_any ? dn_low : '0;
			end
			S_Q_CARRY: begin
				carry_q <= (off == '0 && word_idx != '0) ? pres_rdata[WORD_W-1] : 1'b0;
				chk_q   <= word_idx;
				first_q <= 1'b1;
			end
			S_Q_SCAN: begin
				carry_q <= pres_rdata[WORD_W-1];
				chk_q   <= chk_next;
				first_q <= 1'b0;
				lo_q    <= AW'({chk_q, st_lsb});
				res_q   <= '0;
			end
			S_H_GET: begin
				hi_q                  <= ep_rdata;
				res_q.found           <= 1'b1;
				res_q.already_present <= (cmd_q == CMD_ADD);
				res_q.run_low         <= VALUE_W'(lo_q);
				res_q.run_high        <= VALUE_W'(ep_rdata);
			end
			default: begin
			end
		endcase
	end

	// Output register of the response channel.
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// A run end written to the store never lies below its start.
	`DIT_ASSERT_NEVER(a_ep_order, ep_we && (lo_q > hi_q), "run end written below run start")
	// A run start read back always names a high end at or above itself.
	`DIT_ASSERT(a_hi_ge_lo, (state_q == S_H_GET) |-> (ep_rdata >= lo_q),
		"stored high end lies below run start")
	// A finished response waits while the output register is still occupied.
	`DIT_ASSERT(a_done_hold, (state_q == S_DONE && rsp_valid && !rsp_ready) |=>
		(state_q == S_DONE), "response left before output register was free")
	// An add reports a run that holds the added value.
	`DIT_ASSERT(a_add_cover, (state_q == S_DONE && cmd_q == CMD_ADD && res_q.found) |->
		(PW'(lo_q) <= pos_q && pos_q <= PW'(hi_q)), "add response does not hold value")
	// A query reports a run starting at or after the requested position.
	`DIT_ASSERT(a_query_after, (state_q == S_DONE && cmd_q == CMD_QUERY && res_q.found) |->
		(PW'(lo_q) >= pos_q), "query response starts before requested value")

endmodule
